// ===== src/rptd_pkg.sv =====
// shared types and constants for the roulette pick block
// no dependencies; compiled before every other file
package rptd_pkg;

  localparam int SCORE_W  = 20;
  localparam int RAND_W   = 32;
  localparam int IDX_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOTAL_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REMAIN_ZERO = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV1,
    S_LOC1,
    S_DIV2,
    S_LOC2,
    S_DONE
  } state_t;

endpackage

// ===== src/rptd_if.sv =====
// valid/ready channel interfaces for pick requests and pick results
// depends on rptd_pkg for field widths
interface rptd_req_if import rptd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [IDX_W-1:0]    entry_index;
  logic [SCORE_W-1:0]  score_value;
  logic [RAND_W-1:0]   first_random;
  logic [RAND_W-1:0]   second_random;

  modport source (
    output valid, command, entry_index, score_value, first_random, second_random,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, score_value, first_random, second_random,
    output ready
  );
endinterface

interface rptd_rsp_if import rptd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    first_index;
  logic [IDX_W-1:0]    second_index;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, first_index, second_index, status,
    input  ready
  );
  modport sink (
    input  valid, first_index, second_index, status,
    output ready
  );
endinterface

// ===== src/rptd_store.sv =====
// score store: one write port, one registered read port
// per-entry valid bits make unwritten entries read as zero; uses rptd_pkg
module rptd_store import rptd_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [SCORE_W-1:0]         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [SCORE_W-1:0]         rd_data
);

  logic [SCORE_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ===== src/rptd_div.sv =====
// bit-serial restoring remainder unit: one dividend bit per cycle
// depends on rptd_pkg for the dividend width
module rptd_div import rptd_pkg::*; #(
  parameter int DW = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [DW-1:0]     remainder
);

  localparam int CW = $clog2(RAND_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [RAND_W-1:0] dvd;
  logic [DW-1:0]     dsr;
  logic [DW:0]       trial;
  logic [DW:0]       diff;

  assign trial = {remainder, dvd[RAND_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[RAND_W-2:0], 1'b0};
      // keep the difference when the trial value covers the divisor
      remainder <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
    end
  end

endmodule

// ===== src/roulette_pick_two_distinct.sv =====
// Roulette-wheel pick of two distinct entries from a store of ENTRIES scores.
// Channel req (sink): command 0 writes score_value to entry entry_index
// (entries at or above ENTRIES are ignored), no result beat.
// Command 1 starts a pick using first_random and second_random.
// Channel rsp (source): one beat per pick with first_index, second_index and
// status (0 ok, 1 total score zero, 2 remaining score zero).
// A pick runs a sum scan over the store, a serial remainder (one random bit
// per cycle), a locate scan, a second remainder and a second locate scan,
// then hands off the result. A total score of zero skips straight from the
// sum scan to the hand-off, and a remaining score of zero skips the second
// remainder and locate scan. One pick is in flight at a time; the store's
// single read port and the serial remainder set the pace.
// req.ready is high only between picks; loads are taken every cycle then.
// The result sits in an output register, so a new pick can start while the
// receiver stalls; a finished pick waits until the register frees up.
// Synchronous reset clears all scores to zero, drops rsp.valid and returns
// to idle.
module roulette_pick_two_distinct import rptd_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  rptd_req_if.sink    req,
  rptd_rsp_if.source  rsp
);

  localparam int AW   = $clog2(ENTRIES);
  localparam int SUMW = SCORE_W + AW;

  state_t state, state_next;

  logic [AW:0]          scan_cnt;
  logic                 scan_pend;
  logic [AW-1:0]        scan_idx;
  logic                 scan_state;
  logic                 scan_end;
  logic [SUMW-1:0]      acc;
  logic [SUMW-1:0]      total;
  logic [SUMW-1:0]      total2;
  logic [RAND_W-1:0]    r1;
  logic [RAND_W-1:0]    r2;
  logic                 found;
  logic                 hit;
  logic                 skip;
  logic [AW-1:0]        first;
  logic [AW-1:0]        second;
  logic [SCORE_W-1:0]   first_score;
  logic [STATUS_W-1:0]  res_status;
  logic                 out_valid;
  logic                 out_free;

  logic                 wr_en;
  logic                 rd_en;
  logic [SCORE_W-1:0]   rd_data;
  logic                 div_start;
  logic                 div_done;
  logic [RAND_W-1:0]    div_dividend;
  logic [SUMW-1:0]      div_divisor;
  logic [SUMW-1:0]      target;

  rptd_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (AW'(req.entry_index)),
    .wr_data (req.score_value),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  rptd_div #(.DW(SUMW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (target)
  );

  assign wr_en = req.valid && req.ready && (req.command == CMD_LOAD) &&
                 (32'(req.entry_index) < ENTRIES);

  assign scan_state = (state == S_SUM) || (state == S_LOC1) || (state == S_LOC2);
  assign scan_end   = (scan_cnt == (AW+1)'(ENTRIES)) && !scan_pend;
  assign total2     = total - SUMW'(first_score);
  assign out_free   = !out_valid || rsp.ready;

  // the first pick is left out of the second scan and adds nothing to its span
  assign skip = (state == S_LOC2) && (scan_idx == first);
  assign hit  = scan_pend && !found && !skip &&
                ({1'b0, target} < ({1'b0, acc} + (SUMW+1)'(rd_data)));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid && req.command == CMD_PICK) state_next = S_SUM;
      end
      S_SUM: begin
        if (scan_end) state_next = (acc == '0) ? S_DONE : S_DIV1;
      end
      S_DIV1: begin
        if (div_done) state_next = S_LOC1;
      end
      S_LOC1: begin
        if (scan_end) state_next = (total2 == '0) ? S_DONE : S_DIV2;
      end
      S_DIV2: begin
        if (div_done) state_next = S_LOC2;
      end
      S_LOC2: begin
        if (scan_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready    = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    div_dividend = r1;
    div_divisor  = acc;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_SUM: begin
        rd_en = (scan_cnt != (AW+1)'(ENTRIES));
        div_start = scan_end && (acc != '0);
      end
      S_LOC1: begin
        rd_en        = (scan_cnt != (AW+1)'(ENTRIES));
        div_start    = scan_end && (total2 != '0);
        div_dividend = r2;
        div_divisor  = total2;
      end
      S_LOC2: rd_en = (scan_cnt != (AW+1)'(ENTRIES));
      S_DIV1, S_DIV2, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      scan_cnt  <= '0;
      scan_pend <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (scan_state) begin
        scan_pend <= rd_en;
        if (rd_en) scan_cnt <= scan_cnt + 1'b1;
        if (hit) found <= 1'b1;
      end else begin
        scan_cnt  <= '0;
        scan_pend <= 1'b0;
        found     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_cnt[AW-1:0];
    if (!scan_state) begin
      acc <= '0;
    end else if (scan_pend && !skip) begin
      acc <= acc + SUMW'(rd_data);
    end
    if (state == S_IDLE && req.valid) begin
      r1 <= req.first_random;
      r2 <= req.second_random;
    end
    unique case (state)
      S_SUM: begin
        if (scan_end) begin
          total      <= acc;
          res_status <= ST_TOTAL_ZERO;
          first      <= '0;
          second     <= '0;
        end
      end
      S_LOC1: begin
        if (hit) begin
          first       <= scan_idx;
          first_score <= rd_data;
        end
        if (scan_end) begin
          res_status <= ST_REMAIN_ZERO;
          second     <= '0;
        end
      end
      S_LOC2: begin
        if (hit) second <= scan_idx;
        if (scan_end) res_status <= ST_OK;
      end
      S_IDLE, S_DIV1, S_DIV2, S_DONE: ;
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      rsp.first_index  <= IDX_W'(first);
      rsp.second_index <= IDX_W'(second);
      rsp.status       <= res_status;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ===== src/rptd_check.sv =====
// port-level checks on the roulette pick block's result channel
// bound to roulette_pick_two_distinct; depends on rptd_pkg for status codes
module rptd_check import rptd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [IDX_W-1:0]    first_index,
  input logic [IDX_W-1:0]    second_index,
  input logic [STATUS_W-1:0] status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_index) &&
      $stable(second_index) && $stable(status))
    else $error("result beat changed while stalled");

  a_distinct: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_OK |-> first_index != second_index)
    else $error("ok pick with equal indexes");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_TOTAL_ZERO |-> first_index == '0 && second_index == '0)
    else $error("total-zero result with nonzero index");

  a_remain_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_REMAIN_ZERO |-> second_index == '0)
    else $error("remaining-zero result with nonzero second index");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == ST_OK || status == ST_TOTAL_ZERO || status == ST_REMAIN_ZERO)
    else $error("undefined status code");

endmodule

bind roulette_pick_two_distinct rptd_check u_check (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .first_index  (rsp.first_index),
  .second_index (rsp.second_index),
  .status       (rsp.status)
);
